[rtl/core/bffa_pkg.sv]
// Shared types and constants for the bitmap first-fit block allocator.
`default_nettype none

package bffa_pkg;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [31:0] HEAP_BASE_RESET = 32'h2000_1000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] size_bytes;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] address_out;
    logic        ok;
  } out_item_t;

  // State of one heap block as it travels round the ring
  typedef struct packed {
    logic used;
    logic run_end;
    logic pending;
  } blk_state_t;

  // Broadcast from the head controller to every cell
  typedef struct packed {
    logic shift;
    logic clear;
    logic commit;
    logic drop;
  } ring_ctl_t;

endpackage

`default_nettype wire

[rtl/core/bffa_cell.sv]
// One ring cell: holds the used, end-of-run and tentative bits of one block.
`default_nettype none

module bffa_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  bffa_pkg::ring_ctl_t    ctl,
  input  bffa_pkg::blk_state_t   d,
  output bffa_pkg::blk_state_t   q
);

  bffa_pkg::blk_state_t q_next;

  always_comb begin
    q_next = ctl.shift ? d : q;
    // commit turns a tentative run into a used one
    if (ctl.commit) begin
      q_next.used    = q_next.used | q_next.pending;
      q_next.pending = 1'b0;
    end
    if (ctl.drop) begin
      q_next.pending = 1'b0;
    end
    if (ctl.clear) begin
      q_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bffa_ctrl.sv]
// Head controller: command sequencing, per-block scan at the ring head and result register.
`default_nettype none

module bffa_ctrl #(
  parameter int HEAP_BYTES  = 4096,
  parameter int BLOCK_BYTES = 16,
  parameter int NUM_BLOCKS  = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            heap_base,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  bffa_pkg::in_item_t     in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output bffa_pkg::out_item_t    out_item,
  input  bffa_pkg::blk_state_t   head,
  output bffa_pkg::blk_state_t   tail,
  output bffa_pkg::ring_ctl_t    ctl
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int ACC_W = $clog2(NUM_BLOCKS * BLOCK_BYTES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
  localparam logic [ACC_W-1:0] BLK_STEP = ACC_W'(BLOCK_BYTES);
  localparam logic [31:0]      HEAP_LIM = 32'(HEAP_BYTES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state, state_next;
  logic             is_alloc, is_alloc_next;
  logic [15:0]      size, size_next;
  logic [31:0]      offset, offset_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [ACC_W-1:0] acc, acc_next;
  logic [ACC_W-1:0] run_bytes, run_bytes_next;
  logic [ACC_W-1:0] first_acc, first_acc_next;
  logic             fin, fin_next;
  logic             started, started_next;
  logic             any, any_next;
  bffa_pkg::out_item_t res, res_next;

  logic             accept;
  logic             load_out;
  logic             last;
  logic             active;
  logic [31:0]      in_offset;
  logic [ACC_W-1:0] acc_step;
  logic [ACC_W-1:0] run_sum;
  logic [ACC_W-1:0] first_sel;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign load_out  = (state == ST_DONE) && (!out_valid || !out_stall);
  assign in_offset = in_item.address - heap_base;
  assign last      = (idx == LAST_IDX);
  assign acc_step  = acc + BLK_STEP;
  assign run_sum   = run_bytes + BLK_STEP;
  assign first_sel = (run_bytes == '0) ? acc : first_acc;
  // the addressed block is the first whose end lies past the offset
  assign active    = started || (32'(acc_step) > offset);

  always_comb begin
    state_next     = state;
    is_alloc_next  = is_alloc;
    size_next      = size;
    offset_next    = offset;
    idx_next       = idx;
    acc_next       = acc;
    run_bytes_next = run_bytes;
    first_acc_next = first_acc;
    fin_next       = fin;
    started_next   = started;
    any_next       = any;
    res_next       = res;
    tail           = head;
    ctl            = '0;
    ctl.shift      = (state == ST_SCAN);
    ctl.clear      = accept && (in_item.cmd == bffa_pkg::CMD_CLEAR);

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          is_alloc_next  = (in_item.cmd == bffa_pkg::CMD_ALLOC);
          size_next      = in_item.size_bytes;
          offset_next    = in_offset;
          idx_next       = '0;
          acc_next       = '0;
          run_bytes_next = '0;
          first_acc_next = '0;
          fin_next       = 1'b0;
          started_next   = 1'b0;
          any_next       = 1'b0;
          res_next       = '0;
          state_next     = ST_DONE;
          unique case (in_item.cmd)
            bffa_pkg::CMD_ALLOC: begin
              if ((in_item.size_bytes != 16'd0) && (32'(in_item.size_bytes) <= HEAP_LIM)) begin
                state_next = ST_SCAN;
              end
            end
            bffa_pkg::CMD_FREE: begin
              if ((in_item.address != 32'd0) && (in_offset < HEAP_LIM)) begin
                state_next = ST_SCAN;
              end
            end
            bffa_pkg::CMD_CLEAR: begin
              res_next.ok = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        idx_next = idx + IDX_ONE;
        acc_next = acc_step;
        if (is_alloc) begin
          if (!fin) begin
            if (head.used) begin
              // run broken: restart the count and drop tentative marks
              run_bytes_next = '0;
              ctl.drop       = 1'b1;
            end else begin
              if (run_bytes == '0) begin
                first_acc_next = acc;
              end
              if (32'(run_sum) >= 32'(size)) begin
                ctl.commit           = 1'b1;
                tail.used            = 1'b1;
                tail.run_end         = 1'b1;
                tail.pending         = 1'b0;
                fin_next             = 1'b1;
                res_next.address_out = heap_base + 32'(first_sel);
                res_next.ok          = 1'b1;
              end else begin
                tail.pending   = 1'b1;
                run_bytes_next = run_sum;
              end
            end
          end
          if (last) begin
            ctl.drop = 1'b1;
          end
        end else if (!fin && active) begin
          started_next = 1'b1;
          if (head.used) begin
            tail     = '0;
            any_next = 1'b1;
            if (head.run_end) begin
              fin_next = 1'b1;
            end
          end else begin
            fin_next = 1'b1;
          end
        end
        if (last) begin
          state_next = ST_DONE;
          if (!is_alloc) begin
            res_next.ok = any_next;
          end
        end
      end

      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    is_alloc  <= is_alloc_next;
    size      <= size_next;
    offset    <= offset_next;
    idx       <= idx_next;
    acc       <= acc_next;
    run_bytes <= run_bytes_next;
    first_acc <= first_acc_next;
    fin       <= fin_next;
    started   <= started_next;
    any       <= any_next;
    res       <= res_next;
    if (load_out) begin
      out_item <= res;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bitmap_first_fit_allocator_top.sv]
// Top level of the bitmap first-fit block allocator: base register, block ring and controller.
`default_nettype none

// The heap's block bitmap lives in a ring of NUM_BLOCKS cells that rotates by one block per
// cycle past a head controller while a scan runs. Allocate and free each take one full rotation:
// an item is taken, the scan visits all NUM_BLOCKS blocks at the ring head in turn, and then the
// result register is loaded. Clear, rejected requests and unknown commands skip the scan and go
// straight to loading the result. A new item is taken once the previous result has moved into the
// output register; that result may wait there under stall while the next item is processed.
// heap_base is written through the cfg channel, which is always ready, and should be changed
// only while the block is idle.
module bitmap_first_fit_allocator_top #(
  parameter int HEAP_BYTES  = 4096,
  parameter int BLOCK_BYTES = 16,
  parameter int NUM_BLOCKS  = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [31:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bffa_pkg::in_item_t    in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bffa_pkg::out_item_t   out_item
);

  logic [31:0]          heap_base;
  bffa_pkg::ring_ctl_t  ctl;
  bffa_pkg::blk_state_t tail;
  bffa_pkg::blk_state_t ring [NUM_BLOCKS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= bffa_pkg::HEAP_BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      heap_base <= cfg_data;
    end
  end

  // cell k feeds cell k-1; the controller writes the tail and reads cell 0
  for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
    if (k == NUM_BLOCKS - 1) begin : g_tail
      bffa_cell u_cell (
        .clk (clk),
        .rst (rst),
        .ctl (ctl),
        .d   (tail),
        .q   (ring[k])
      );
    end else begin : g_mid
      bffa_cell u_cell (
        .clk (clk),
        .rst (rst),
        .ctl (ctl),
        .d   (ring[k+1]),
        .q   (ring[k])
      );
    end
  end

  bffa_ctrl #(
    .HEAP_BYTES  (HEAP_BYTES),
    .BLOCK_BYTES (BLOCK_BYTES),
    .NUM_BLOCKS  (NUM_BLOCKS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .heap_base (heap_base),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .head      (ring[0]),
    .tail      (tail),
    .ctl       (ctl)
  );

endmodule

`default_nettype wire

[rtl/core/bffa_checker.sv]
// Port-level checks for the allocator top level, bound to it.
`default_nettype none

module bffa_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input bffa_pkg::out_item_t   out_item
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // one item at a time: a taken item blocks the input
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an item was taken");

  // a new result only appears while an item is in flight
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result with no item in flight");

  // a failed or ignored item reports a null address
  a_fail_null: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.ok |-> out_item.address_out == 32'd0)
    else $error("failed item with non-null address");

endmodule

bind bitmap_first_fit_allocator_top bffa_checker u_bffa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
